// ----- rtl/lpm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants of the longest prefix match router
// Route and command records, result codes and the prefix mask helper.
// ----------------------------------------------------------------------------
package lpm_pkg;

   localparam int TABLE_DEPTH    = 64;
   localparam int QUEUE_DEPTH    = 2;
   localparam int REQ_DATA_WIDTH = 120;
   localparam int RSP_DATA_WIDTH = 48;

   localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;
   localparam logic [7:0] TTL_LAST_HOP   = 8'd1;

   typedef enum logic [2:0] {
      STAT_ADDED   = 3'd0,
      STAT_FULL    = 3'd1,
      STAT_FORWARD = 3'd2,
      STAT_NOROUTE = 3'd3,
      STAT_EXPIRED = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      FUNC_ADD    = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic        hop_valid;
      logic [31:0] hop_addr;
      logic [3:0]  port;
   } route_type;

   localparam int ROUTE_WIDTH = $bits(route_type);

   typedef struct packed {
      func_type    func;
      route_type   route;
      logic [31:0] dest;
      logic [7:0]  ttl;
   } cmd_type;

   // Packed so that status lands in the lowest bits of the result beat.
   typedef struct packed {
      logic [7:0]  ttl;
      logic [31:0] target;
      logic [3:0]  port;
      status_type  status;
   } result_type;

   // Mask of the len high-order bits; len is at most 32.
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      prefix_mask = ~(32'hFFFF_FFFF >> len);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/lpm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/lpm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_front: request intake and command queue
// Decodes request beats into route or lookup commands and buffers them.
// ----------------------------------------------------------------------------
module lpm_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [lpm_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   input  wire logic [0:0]                             req_tuser,
   output logic                                        cmd_valid,
   output lpm_pkg::cmd_type                            cmd,
   input  wire logic                                   cmd_pop
);

   localparam int QW = (lpm_pkg::QUEUE_DEPTH > 1) ? $clog2(lpm_pkg::QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(lpm_pkg::QUEUE_DEPTH + 1);

   lpm_pkg::cmd_type queue_ff [lpm_pkg::QUEUE_DEPTH];
   logic [QW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             push;
   lpm_pkg::cmd_type new_cmd;
   logic [5:0]       raw_len;

   // Field decode; lengths above 32 are stored as 32.
   always_comb begin
      raw_len                 = req_tdata[37:32];
      new_cmd.func            = lpm_pkg::func_type'(req_tuser[0]);
      new_cmd.route.prefix    = req_tdata[31:0];
      new_cmd.route.len       = (raw_len > lpm_pkg::MAX_PREFIX_LEN) ?
                                lpm_pkg::MAX_PREFIX_LEN : raw_len;
      new_cmd.route.hop_valid = req_tdata[38];
      new_cmd.route.hop_addr  = req_tdata[38] ? req_tdata[70:39] : 32'd0;
      new_cmd.route.port      = req_tdata[74:71];
      new_cmd.dest            = req_tdata[106:75];
      new_cmd.ttl             = req_tdata[114:107];
   end

   assign req_tready = (fill_ff != FW'(lpm_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (fill_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(lpm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(lpm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/lpm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_back: route table and lookup engine
// Appends routes to the table RAM and scans it one entry per cycle for the
// longest matching prefix; the result waits in an output register.
// ----------------------------------------------------------------------------
module lpm_back #(
   parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                cmd_valid,
   input  wire lpm_pkg::cmd_type                    cmd,
   output logic                                     cmd_pop,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [lpm_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_SCAN = 3'b010,
      BK_FIN  = 3'b100
   } bk_state_type;

   bk_state_type         state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic                 found_ff, found_in;
   logic [5:0]           best_len_ff, best_len_in;
   logic [3:0]           best_port_ff, best_port_in;
   logic                 best_hop_valid_ff, best_hop_valid_in;
   logic [31:0]          best_hop_ff, best_hop_in;
   logic [31:0]          dest_ff, dest_in;
   logic [7:0]           ttl_ff, ttl_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lpm_pkg::result_type  rsp_data_ff, rsp_data_in;

   logic                 out_free;
   logic                 wr_en;
   logic                 rd_en;
   lpm_pkg::route_type   rd_route;
   logic [lpm_pkg::ROUTE_WIDTH-1:0] rd_bits;
   logic [31:0]          mask;
   logic                 hit;

   lpm_ram #(
      .WIDTH (lpm_pkg::ROUTE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (cmd.route),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_route = lpm_pkg::route_type'(rd_bits);
   assign mask     = lpm_pkg::prefix_mask(rd_route.len);
   assign hit      = ((rd_route.prefix & mask) == (dest_ff & mask));
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      idx_in            = idx_ff;
      pend_in           = 1'b0;
      found_in          = found_ff;
      best_len_in       = best_len_ff;
      best_port_in      = best_port_ff;
      best_hop_valid_in = best_hop_valid_ff;
      best_hop_in       = best_hop_ff;
      dest_in           = dest_ff;
      ttl_in            = ttl_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_data_in       = rsp_data_ff;
      cmd_pop           = 1'b0;
      wr_en             = 1'b0;
      rd_en             = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.func == lpm_pkg::FUNC_LOOKUP) begin
                  cmd_pop  = 1'b1;
                  dest_in  = cmd.dest;
                  ttl_in   = cmd.ttl;
                  found_in = 1'b0;
                  idx_in   = '0;
                  state_in = BK_SCAN;
               end else if (out_free) begin
                  cmd_pop      = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  if (count_ff != CW'(TABLE_DEPTH)) begin
                     wr_en              = 1'b1;
                     count_in           = count_ff + 1'b1;
                     rsp_data_in.status = lpm_pkg::STAT_ADDED;
                  end else begin
                     rsp_data_in.status = lpm_pkg::STAT_FULL;
                  end
               end
            end
         end
         BK_SCAN: begin
            // Read of entry idx issued now; its data is checked next cycle.
            if (idx_ff != count_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = BK_FIN;
            end
            // Strictly longer wins, so ties keep the earlier entry.
            if (pend_ff && hit && (!found_ff || rd_route.len > best_len_ff)) begin
               found_in          = 1'b1;
               best_len_in       = rd_route.len;
               best_port_in      = rd_route.port;
               best_hop_valid_in = rd_route.hop_valid;
               best_hop_in       = rd_route.hop_addr;
            end
         end
         BK_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (!found_ff) begin
                  rsp_data_in.status = lpm_pkg::STAT_NOROUTE;
               end else if (ttl_ff <= lpm_pkg::TTL_LAST_HOP) begin
                  rsp_data_in.status = lpm_pkg::STAT_EXPIRED;
               end else begin
                  rsp_data_in.status = lpm_pkg::STAT_FORWARD;
                  rsp_data_in.port   = best_port_ff;
                  rsp_data_in.target = best_hop_valid_ff ? best_hop_ff : dest_ff;
                  rsp_data_in.ttl    = ttl_ff - 8'd1;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_len_ff       <= best_len_in;
      best_port_ff      <= best_port_in;
      best_hop_valid_ff <= best_hop_valid_in;
      best_hop_ff       <= best_hop_in;
      dest_ff           <= dest_in;
      ttl_ff            <= ttl_in;
      rsp_data_ff       <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lpm_pkg::RSP_DATA_WIDTH - $bits(lpm_pkg::result_type)){1'b0}},
                        rsp_data_ff};

endmodule
`default_nettype wire

// ----- rtl/longest_prefix_match_router_top.sv -----
// An add's result beat is registered as the add leaves the command queue; a lookup's
// result beat is registered once the table scan, reading one entry per cycle, has
// covered every stored route. Adds go out one per cycle while no lookup is under way
// and the result register is free; a lookup holds the engine until its result is registered.
// Reset is synchronous and active high: it empties the queue and the table
// count at once; table contents are left as they are and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_prefix_match_router_top: IPv4 longest prefix match routing table
// Request intake and queue in front, route table and lookup engine behind.
// ----------------------------------------------------------------------------
module longest_prefix_match_router_top #(
   parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // route_addr[31:0], route_len[37:32], hop_present[38], hop_addr[70:39],
   // port_index[74:71], dest_addr[106:75], hop_limit[114:107], zero fill
   input  wire logic [lpm_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // func[0]
   input  wire logic [0:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // status[2:0], out_port[6:3], target_addr[38:7], new_hop_limit[46:39], zero fill
   output logic [lpm_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata
);

   logic             cmd_valid;
   lpm_pkg::cmd_type cmd;
   logic             cmd_pop;

   lpm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   lpm_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

   a_full_queue_offers: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> cmd_valid)
      else $error("queue refuses beats while holding no command");

   a_add_answers: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.func == lpm_pkg::FUNC_ADD) |=> rsp_tvalid)
      else $error("add command left without a result");

   a_forward_ttl: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == lpm_pkg::STAT_FORWARD) |-> (rsp_tdata[46:39] != 8'd0))
      else $error("forwarded datagram with zero ttl");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the longest prefix match router
// Route adds and destination lookups are streamed into the router with random
// gaps and back-pressure. A shadow routing table in the bench computes the
// outcome of every accepted beat, and each result beat is compared field by
// field against the oldest outstanding outcome.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_ITEMS   = 480;
   localparam int DEFAULT_AT     = 56;

   typedef struct {
      lpm_pkg::func_type func;
      logic [31:0] route_addr;
      logic [5:0]  route_len;
      logic        hop_present;
      logic [31:0] hop_addr;
      logic [3:0]  port_index;
      logic [31:0] dest_addr;
      logic [7:0]  hop_limit;
   } datagram_req_type;

   typedef struct {
      lpm_pkg::status_type status;
      logic [3:0]  out_port;
      logic [31:0] target_addr;
      logic [7:0]  new_hop_limit;
   } route_rsp_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [lpm_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [0:0]                         req_tuser = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [lpm_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;

   longest_prefix_match_router_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow routing table, updated in acceptance order.
   logic [31:0]   tbl_prefix [lpm_pkg::TABLE_DEPTH];
   logic [5:0]    tbl_len    [lpm_pkg::TABLE_DEPTH];
   logic          tbl_hop_ok [lpm_pkg::TABLE_DEPTH];
   logic [31:0]   tbl_hop    [lpm_pkg::TABLE_DEPTH];
   logic [3:0]    tbl_port   [lpm_pkg::TABLE_DEPTH];
   int            routes_stored = 0;

   datagram_req_type pending_reqs [$];
   route_rsp_type    outcome_q [$];
   datagram_req_type req_cur;
   logic             req_taken = 1'b0;
   int               queued_cnt = 0;
   int               accepted_cnt = 0;
   int               rsp_count = 0;
   int               mismatches = 0;
   int               src_idle_pct = 0;
   int               sink_idle_pct = 0;

   // Prefixes the stimulus has already sent, used to aim lookups at real routes.
   logic [31:0] sent_prefix [$];
   logic [5:0]  sent_len [$];

   function automatic logic [31:0] len_mask(input logic [5:0] len);
      if (len == 6'd0) return 32'h0;
      return 32'hFFFF_FFFF << (6'd32 - len);
   endfunction

   function automatic int idle_length(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic route_rsp_type forward_decision(input datagram_req_type r);
      route_rsp_type o;
      int            best;
      int            k;
      logic [5:0]    best_len;
      logic [5:0]    len;
      logic [31:0]   m;
      o.status = lpm_pkg::STAT_ADDED;
      o.out_port = '0;
      o.target_addr = '0;
      o.new_hop_limit = '0;
      best = -1;
      best_len = '0;
      if (r.func == lpm_pkg::FUNC_ADD) begin
         if (routes_stored >= lpm_pkg::TABLE_DEPTH) begin
            o.status = lpm_pkg::STAT_FULL;
         end else begin
            len = (r.route_len > lpm_pkg::MAX_PREFIX_LEN) ? lpm_pkg::MAX_PREFIX_LEN :
                  r.route_len;
            tbl_prefix[routes_stored] = r.route_addr;
            tbl_len[routes_stored]    = len;
            tbl_hop_ok[routes_stored] = r.hop_present;
            tbl_hop[routes_stored]    = r.hop_addr;
            tbl_port[routes_stored]   = r.port_index;
            routes_stored++;
         end
      end else begin
         for (k = 0; k < routes_stored; k++) begin
            m = len_mask(tbl_len[k]);
            // Strictly longer wins, so the earliest of equal lengths stays.
            if (((tbl_prefix[k] ^ r.dest_addr) & m) == 32'h0 &&
                (best < 0 || tbl_len[k] > best_len)) begin
               best = k;
               best_len = tbl_len[k];
            end
         end
         if (best < 0) begin
            o.status = lpm_pkg::STAT_NOROUTE;
         end else if (r.hop_limit <= lpm_pkg::TTL_LAST_HOP) begin
            o.status = lpm_pkg::STAT_EXPIRED;
         end else begin
            o.status = lpm_pkg::STAT_FORWARD;
            o.out_port = tbl_port[best];
            o.target_addr = tbl_hop_ok[best] ? tbl_hop[best] : r.dest_addr;
            o.new_hop_limit = r.hop_limit - 8'd1;
         end
      end
      return o;
   endfunction

   // Fields that belong to the lookup are filled with noise on an add.
   function automatic datagram_req_type make_add(input logic [31:0] addr,
                                                 input logic [5:0] len,
                                                 input logic hp,
                                                 input logic [31:0] hop,
                                                 input logic [3:0] port);
      datagram_req_type r;
      r.func = lpm_pkg::FUNC_ADD;
      r.route_addr = addr;
      r.route_len = len;
      r.hop_present = hp;
      r.hop_addr = hop;
      r.port_index = port;
      r.dest_addr = $urandom();
      r.hop_limit = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic datagram_req_type make_lookup(input logic [31:0] dest,
                                                    input logic [7:0] ttl);
      datagram_req_type r;
      r.func = lpm_pkg::FUNC_LOOKUP;
      r.route_addr = $urandom();
      r.route_len = 6'($urandom_range(0, 63));
      r.hop_present = 1'($urandom_range(0, 1));
      r.hop_addr = $urandom();
      r.port_index = 4'($urandom_range(0, 15));
      r.dest_addr = dest;
      r.hop_limit = ttl;
      return r;
   endfunction

   task automatic offer(input datagram_req_type r);
      while (pending_reqs.size() >= 8) @(posedge clock);
      if (r.func == lpm_pkg::FUNC_ADD && sent_prefix.size() < lpm_pkg::TABLE_DEPTH) begin
         sent_prefix.push_back(r.route_addr);
         sent_len.push_back((r.route_len > lpm_pkg::MAX_PREFIX_LEN) ?
                            lpm_pkg::MAX_PREFIX_LEN : r.route_len);
      end
      pending_reqs.push_back(r);
      queued_cnt++;
   endtask

   task automatic wait_drained();
      while (accepted_cnt != queued_cnt || outcome_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   // Request driver: a new beat goes out once the previous one was taken.
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_cur = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= req_cur.func;
            req_tdata <= {5'b0, req_cur.hop_limit, req_cur.dest_addr, req_cur.port_index,
                          req_cur.hop_addr, req_cur.hop_present, req_cur.route_len,
                          req_cur.route_addr};
            gap_left = idle_length(src_idle_pct);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result sink, with one long hold-off once traffic is well under way.
   int  stall_left = 0;
   logic long_hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && rsp_count >= 300) begin
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = idle_length(sink_idle_pct);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: checks result beats and records accepted request beats.
   route_rsp_type want;
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (outcome_q.size() == 0) begin
               $error("result beat with no request outstanding: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tdata[2:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[2:0]);
                  mismatches++;
               end
               if (rsp_tdata[6:3] !== want.out_port) begin
                  $error("out_port: expected %0d, got %0d", want.out_port, rsp_tdata[6:3]);
                  mismatches++;
               end
               if (rsp_tdata[38:7] !== want.target_addr) begin
                  $error("target_addr: expected %h, got %h", want.target_addr,
                         rsp_tdata[38:7]);
                  mismatches++;
               end
               if (rsp_tdata[46:39] !== want.new_hop_limit) begin
                  $error("new_hop_limit: expected %0d, got %0d", want.new_hop_limit,
                         rsp_tdata[46:39]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(forward_decision(req_cur));
            accepted_cnt++;
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          i;
      int          k;
      int unsigned roll;
      logic [5:0]  len;
      logic [31:0] m;
      logic [31:0] dest;
      logic [7:0]  ttl;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed part. The default route and the full table come later, since
      // either one would hide the no-route case for the rest of the run.
      offer(make_lookup($urandom(), 8'd0));      // no route wins over a dead TTL
      offer(make_lookup(32'hFFFF_FFFF, 8'd255));
      offer(make_add(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0001, 4'd1));
      offer(make_add(32'h0A01_0000, 6'd16, 1'b0, 32'hDEAD_BEEF, 4'd2));
      offer(make_add(32'h0A01_0203, 6'd32, 1'b1, 32'h0000_0000, 4'd15));
      offer(make_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0101_0101, 4'd3));
      offer(make_add(32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd0));
      offer(make_add(32'hAC1F_FFFF, 6'd12, 1'b0, 32'h0, 4'd7));
      offer(make_add(32'h5555_5555, 6'd33, 1'b1, 32'hAAAA_AAAA, 4'd9));
      offer(make_lookup(32'h0A01_0203, 8'd64));
      offer(make_lookup(32'h0A01_0909, 8'd2));   // tie on /16 goes to the first
      offer(make_lookup(32'h0AC8_0001, 8'd255));
      offer(make_lookup(32'h0A01_0203, 8'd1));
      offer(make_lookup(32'h0A01_0203, 8'd0));
      offer(make_lookup(32'hFFFF_FFFF, 8'd255));
      offer(make_lookup(32'hFFFF_FFFE, 8'd9));
      offer(make_lookup(32'hAC10_00AA, 8'd100));
      offer(make_lookup(32'h5555_5555, 8'd7));
      offer(make_lookup(32'h0000_0000, 8'd3));
      wait_drained();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            case (i / 100)
               0: begin src_idle_pct = 0;  sink_idle_pct = 30; end
               1: begin src_idle_pct = 25; sink_idle_pct = 0;  end
               2: begin src_idle_pct = 50; sink_idle_pct = 50; end
               3: begin src_idle_pct = 10; sink_idle_pct = 15; end
               default: begin src_idle_pct = 35; sink_idle_pct = 0; end
            endcase
         end
         // Let everything in flight come back before going on.
         if (i == 200) wait_drained();
         roll = $urandom_range(0, 99);
         if (roll < ((i < 300) ? 25 : 15)) begin
            if (sent_prefix.size() == DEFAULT_AT) begin
               len = 6'd0;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 50) len = 6'($urandom_range(8, 24));
               else if (roll < 70) len = 6'($urandom_range(25, 32));
               else if (roll < 85) len = 6'($urandom_range(33, 63));
               else len = 6'($urandom_range(1, 7));
            end
            // Some routes reuse a known prefix to build nested and equal matches.
            if (sent_prefix.size() > 0 && $urandom_range(0, 9) < 3)
               dest = sent_prefix[$urandom_range(0, sent_prefix.size() - 1)];
            else
               dest = $urandom();
            offer(make_add(dest, len, 1'($urandom_range(0, 1)), $urandom(),
                           4'($urandom_range(0, 15))));
         end else begin
            if (sent_prefix.size() > 0 && $urandom_range(0, 9) < 7) begin
               k = $urandom_range(0, sent_prefix.size() - 1);
               m = len_mask(sent_len[k]);
               dest = (sent_prefix[k] & m) | ($urandom() & ~m);
            end else begin
               dest = $urandom();
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) ttl = 8'd0;
            else if (roll < 20) ttl = 8'd1;
            else if (roll < 30) ttl = 8'd2;
            else if (roll < 35) ttl = 8'd255;
            else ttl = 8'($urandom_range(0, 255));
            offer(make_lookup(dest, ttl));
         end
      end

      wait_drained();
      repeat (lpm_pkg::TABLE_DEPTH + 16) @(posedge clock);
      if (mismatches == 0 && outcome_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
